// File: hw/rtl/script_text_tokenizer_assert.svh
// Assertion macros for the tokenizer RTL; the packet queue uses them.
`ifndef SCRIPT_TEXT_TOKENIZER_ASSERT_SVH
`define SCRIPT_TEXT_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define STT_ASSERT(lbl, prop, msg)
`define STT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/stt_pkg.sv
// Types and constants shared by the script text tokenizer.
`default_nettype none
package stt_pkg;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_SLASH   = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_WORD    = 3'd3;
  localparam logic [2:0] MODE_QUOTE   = 3'd4;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;

  localparam logic [1:0] CLASS_WORD  = 2'd0;
  localparam logic [1:0] CLASS_QUOTE = 2'd1;
  localparam logic [1:0] CLASS_PUNCT = 2'd2;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_HIGH    = 8'h80;

  localparam int MAX_ITEMS = 4;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] kind;
    logic [1:0] cls;
  } item_t;

  typedef struct packed {
    item_t [MAX_ITEMS-1:0] items;
    logic [CNT_W-1:0]      count;
  } packet_t;

endpackage
`default_nettype wire

// File: hw/rtl/stt_front.sv
// Front end: takes text bytes, tracks the scan mode and builds result packets.
`default_nettype none
module stt_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      text_byte,
  input  wire logic            q_full,
  output logic                 push,
  output stt_pkg::packet_t     pkt
);

  logic [2:0]                mode;
  logic [2:0]                mode_next;
  logic [stt_pkg::CNT_W-1:0] cnt;
  logic                      accept;
  logic                      b_space;
  logic                      b_punct;

  function automatic stt_pkg::item_t mk(input logic [7:0] c, input logic [1:0] k,
                                        input logic [1:0] cl);
    stt_pkg::item_t it;
    it.ch   = c;
    it.kind = k;
    it.cls  = cl;
    return it;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (cnt != '0);

  assign b_space = (text_byte <= stt_pkg::CH_SPACE) || (text_byte >= stt_pkg::CH_HIGH);
  assign b_punct = (text_byte == stt_pkg::CH_LBRACE) || (text_byte == stt_pkg::CH_RBRACE) ||
                   (text_byte == stt_pkg::CH_LPAREN) || (text_byte == stt_pkg::CH_RPAREN) ||
                   (text_byte == stt_pkg::CH_SQUOTE) || (text_byte == stt_pkg::CH_COMMA);

  always_comb begin
    pkt       = '0;
    cnt       = '0;
    mode_next = mode;
    if (text_byte == stt_pkg::CH_NUL) begin
      if (mode == stt_pkg::MODE_WORD) begin
        pkt.items[cnt[stt_pkg::IDX_W-1:0]] = mk(8'h00, stt_pkg::KIND_END, stt_pkg::CLASS_WORD);
        cnt = cnt + 1'b1;
      end else if (mode == stt_pkg::MODE_QUOTE) begin
        pkt.items[cnt[stt_pkg::IDX_W-1:0]] = mk(8'h00, stt_pkg::KIND_END, stt_pkg::CLASS_QUOTE);
        cnt = cnt + 1'b1;
      end else if (mode == stt_pkg::MODE_SLASH) begin
        pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
          mk(stt_pkg::CH_SLASH, stt_pkg::KIND_CHAR, stt_pkg::CLASS_WORD);
        cnt = cnt + 1'b1;
        pkt.items[cnt[stt_pkg::IDX_W-1:0]] = mk(8'h00, stt_pkg::KIND_END, stt_pkg::CLASS_WORD);
        cnt = cnt + 1'b1;
      end
      pkt.items[cnt[stt_pkg::IDX_W-1:0]] = mk(8'h00, stt_pkg::KIND_TEXT, stt_pkg::CLASS_WORD);
      cnt = cnt + 1'b1;
      mode_next = stt_pkg::MODE_IDLE;
    end else begin
      unique case (mode)
        stt_pkg::MODE_SLASH, stt_pkg::MODE_WORD: begin
          if (mode == stt_pkg::MODE_SLASH && text_byte == stt_pkg::CH_SLASH) begin
            mode_next = stt_pkg::MODE_COMMENT;
          end else begin
            if (mode == stt_pkg::MODE_SLASH) begin
              pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
                mk(stt_pkg::CH_SLASH, stt_pkg::KIND_CHAR, stt_pkg::CLASS_WORD);
              cnt = cnt + 1'b1;
            end
            if (b_punct || b_space) begin
              pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
                mk(8'h00, stt_pkg::KIND_END, stt_pkg::CLASS_WORD);
              cnt = cnt + 1'b1;
              if (b_punct) begin
                pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
                  mk(text_byte, stt_pkg::KIND_CHAR, stt_pkg::CLASS_PUNCT);
                cnt = cnt + 1'b1;
                pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
                  mk(8'h00, stt_pkg::KIND_END, stt_pkg::CLASS_PUNCT);
                cnt = cnt + 1'b1;
              end
              mode_next = stt_pkg::MODE_IDLE;
            end else begin
              pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
                mk(text_byte, stt_pkg::KIND_CHAR, stt_pkg::CLASS_WORD);
              cnt = cnt + 1'b1;
              mode_next = stt_pkg::MODE_WORD;
            end
          end
        end
        stt_pkg::MODE_COMMENT: begin
          if (text_byte == stt_pkg::CH_NL) begin
            mode_next = stt_pkg::MODE_IDLE;
          end
        end
        stt_pkg::MODE_QUOTE: begin
          if (text_byte == stt_pkg::CH_DQUOTE) begin
            pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
              mk(8'h00, stt_pkg::KIND_END, stt_pkg::CLASS_QUOTE);
            cnt = cnt + 1'b1;
            mode_next = stt_pkg::MODE_IDLE;
          end else begin
            pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
              mk(text_byte, stt_pkg::KIND_CHAR, stt_pkg::CLASS_QUOTE);
            cnt = cnt + 1'b1;
          end
        end
        default: begin
          if (b_space) begin
            mode_next = stt_pkg::MODE_IDLE;
          end else if (text_byte == stt_pkg::CH_SLASH) begin
            mode_next = stt_pkg::MODE_SLASH;
          end else if (text_byte == stt_pkg::CH_DQUOTE) begin
            mode_next = stt_pkg::MODE_QUOTE;
          end else if (b_punct) begin
            pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
              mk(text_byte, stt_pkg::KIND_CHAR, stt_pkg::CLASS_PUNCT);
            cnt = cnt + 1'b1;
            pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
              mk(8'h00, stt_pkg::KIND_END, stt_pkg::CLASS_PUNCT);
            cnt = cnt + 1'b1;
            mode_next = stt_pkg::MODE_IDLE;
          end else begin
            pkt.items[cnt[stt_pkg::IDX_W-1:0]] =
              mk(text_byte, stt_pkg::KIND_CHAR, stt_pkg::CLASS_WORD);
            cnt = cnt + 1'b1;
            mode_next = stt_pkg::MODE_WORD;
          end
        end
      endcase
    end
    pkt.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stt_pkg::MODE_IDLE;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/stt_queue.sv
// Packet queue between the front end and the output serialiser.
`default_nettype none
`include "script_text_tokenizer_assert.svh"
module stt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire stt_pkg::packet_t push_pkt,
  output logic                  full,
  input  wire logic             pop,
  output stt_pkg::packet_t      head_pkt,
  output logic                  empty
);

  stt_pkg::packet_t           slots [stt_pkg::QDEPTH];
  logic [stt_pkg::QPTR_W-1:0] wr_ptr;
  logic [stt_pkg::QPTR_W-1:0] rd_ptr;
  logic [stt_pkg::QCNT_W-1:0] count;

  assign full     = (count == stt_pkg::QCNT_W'(stt_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign head_pkt = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + stt_pkg::QCNT_W'(push) - stt_pkg::QCNT_W'(pop);
    end
  end

  `STT_ASSERT_NEVER(a_no_overflow, push && full, "Packet pushed into a full queue.")
  `STT_ASSERT_NEVER(a_no_underflow, pop && empty, "Packet popped from an empty queue.")
  `STT_ASSERT(a_count_track, 1'b1 |=> (count == $past(count) + stt_pkg::QCNT_W'($past(push)) - stt_pkg::QCNT_W'($past(pop))), "Queue fill count lost track.")

endmodule
`default_nettype wire

// File: hw/rtl/stt_back.sv
// Back end: hands out the items of the head packet one word per cycle while out_stall is low.
`default_nettype none
module stt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stt_pkg::packet_t head_pkt,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            token_char,
  output logic [1:0]            item_kind,
  output logic [1:0]            token_class,
  output logic                  last_of_run
);

  logic [stt_pkg::IDX_W-1:0] idx;
  logic                      take;
  stt_pkg::item_t            cur;

  assign cur         = head_pkt.items[idx];
  assign out_valid   = !empty;
  assign take        = out_valid && !out_stall;
  assign last_of_run = ({1'b0, idx} == (head_pkt.count - 1'b1));
  assign pop         = take && last_of_run;
  assign token_char  = cur.ch;
  assign item_kind   = cur.kind;
  assign token_class = cur.cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last_of_run ? '0 : idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/script_text_tokenizer.sv
// Top level of the script text tokenizer: front end, packet queue and serialiser.
// Latency: a result word can be taken in the cycle after its byte is accepted.
// Throughput: one text byte per cycle while the queue is not full; the output gives one word
// per cycle while out_stall is low, and up to four packets are queued.
// Input stalls only while the four-entry packet queue is full.
// Reset: synchronous; returns the scan mode to idle and empties the queue.
`default_nettype none
module script_text_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      token_char,
  output logic [1:0]      item_kind,
  output logic [1:0]      token_class,
  output logic            last_of_run
);

  stt_pkg::packet_t push_pkt;
  stt_pkg::packet_t head_pkt;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  stt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .q_full    (q_full),
    .push      (push),
    .pkt       (push_pkt)
  );

  stt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (q_full),
    .pop      (pop),
    .head_pkt (head_pkt),
    .empty    (q_empty)
  );

  stt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_pkt    (head_pkt),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_char  (token_char),
    .item_kind   (item_kind),
    .token_class (token_class),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

// File: tb/tokenizer_result_check.sv
// Checker for the script text tokenizer: predicts the result words of each byte and compares them.
`timescale 1ns / 100ps
module tokenizer_result_check
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] token_char,
  input  logic [1:0] item_kind,
  input  logic [1:0] token_class,
  input  logic       last_of_run,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] kind;
    logic [1:0] cls;
    logic       last;
  } token_word_t;

  logic [2:0]  scan_mode = MODE_IDLE;
  token_word_t token_words_q[$];
  int          errs = 0;

  function automatic bit is_blank(logic [7:0] b);
    return (b <= CH_SPACE) || (b >= CH_HIGH);
  endfunction

  function automatic bit is_punct(logic [7:0] b);
    return b inside {CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SQUOTE, CH_COMMA};
  endfunction

  task automatic push_word(logic [7:0] ch, logic [1:0] kind, logic [1:0] cls);
    token_word_t w;
    w.ch   = (kind == KIND_CHAR) ? ch : CH_NUL;
    w.kind = kind;
    w.cls  = (kind == KIND_TEXT) ? CLASS_WORD : cls;
    w.last = 1'b0;
    token_words_q.push_back(w);
  endtask

  task automatic start_token(logic [7:0] b);
    if (is_blank(b)) begin
      scan_mode = MODE_IDLE;
    end else if (b == CH_SLASH) begin
      scan_mode = MODE_SLASH;
    end else if (b == CH_DQUOTE) begin
      scan_mode = MODE_QUOTE;
    end else if (is_punct(b)) begin
      push_word(b, KIND_CHAR, CLASS_PUNCT);
      push_word(CH_NUL, KIND_END, CLASS_PUNCT);
      scan_mode = MODE_IDLE;
    end else begin
      push_word(b, KIND_CHAR, CLASS_WORD);
      scan_mode = MODE_WORD;
    end
  endtask

  task automatic continue_word(logic [7:0] b);
    if (is_punct(b)) begin
      push_word(CH_NUL, KIND_END, CLASS_WORD);
      start_token(b);
    end else if (is_blank(b)) begin
      push_word(CH_NUL, KIND_END, CLASS_WORD);
      scan_mode = MODE_IDLE;
    end else begin
      push_word(b, KIND_CHAR, CLASS_WORD);
      scan_mode = MODE_WORD;
    end
  endtask

  task automatic predict_byte(logic [7:0] b);
    int start_size;
    start_size = token_words_q.size();
    if (b == CH_NUL) begin
      case (scan_mode)
        MODE_WORD: begin
          push_word(CH_NUL, KIND_END, CLASS_WORD);
        end
        MODE_QUOTE: begin
          push_word(CH_NUL, KIND_END, CLASS_QUOTE);
        end
        MODE_SLASH: begin
          push_word(CH_SLASH, KIND_CHAR, CLASS_WORD);
          push_word(CH_NUL, KIND_END, CLASS_WORD);
        end
        default: begin
        end
      endcase
      push_word(CH_NUL, KIND_TEXT, CLASS_WORD);
      scan_mode = MODE_IDLE;
    end else begin
      case (scan_mode)
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            scan_mode = MODE_COMMENT;
          end else begin
            push_word(CH_SLASH, KIND_CHAR, CLASS_WORD);
            continue_word(b);
          end
        end
        MODE_COMMENT: begin
          if (b == CH_NL) scan_mode = MODE_IDLE;
        end
        MODE_WORD: begin
          continue_word(b);
        end
        MODE_QUOTE: begin
          if (b == CH_DQUOTE) begin
            push_word(CH_NUL, KIND_END, CLASS_QUOTE);
            scan_mode = MODE_IDLE;
          end else begin
            push_word(b, KIND_CHAR, CLASS_QUOTE);
          end
        end
        default: begin
          start_token(b);
        end
      endcase
    end
    if (token_words_q.size() > start_size) token_words_q[token_words_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    token_word_t exp_w;
    if (rst) begin
      scan_mode = MODE_IDLE;
      token_words_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_byte(text_byte);
      if (out_valid && !out_stall) begin
        if (token_words_q.size() == 0) begin
          $error("unexpected result word: token_char %0h, item_kind %0d, token_class %0d",
                 token_char, item_kind, token_class);
          errs++;
        end else begin
          exp_w = token_words_q.pop_front();
          if (token_char !== exp_w.ch) begin
            $error("token_char: expected %0h, got %0h", exp_w.ch, token_char);
            errs++;
          end
          if (item_kind !== exp_w.kind) begin
            $error("item_kind: expected %0d, got %0d", exp_w.kind, item_kind);
            errs++;
          end
          if (token_class !== exp_w.cls) begin
            $error("token_class: expected %0d, got %0d", exp_w.cls, token_class);
            errs++;
          end
          if (last_of_run !== exp_w.last) begin
            $error("last_of_run: expected %0d, got %0d", exp_w.last, last_of_run);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= token_words_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the tokenizer testbench: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module tb_top;
  import stt_pkg::*;

  localparam int TEXT_ITEMS = 226;
  localparam int IDLE_LIMIT = 2000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] text_byte = CH_NUL;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] token_char;
  logic [1:0] item_kind;
  logic [1:0] token_class;
  logic       last_of_run;
  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  int         sent = 0;
  bit         no_gaps = 1'b0;

  logic [7:0] directed_text[$] = '{
    8'h41, CH_DQUOTE, CH_SLASH, CH_LBRACE, CH_RBRACE,
    CH_DQUOTE, CH_SPACE, 8'hFF, CH_DQUOTE, CH_DQUOTE, CH_DQUOTE,
    CH_SLASH, CH_LPAREN, CH_SLASH, 8'h7F, CH_SQUOTE, CH_RPAREN, CH_COMMA,
    CH_SLASH, CH_SLASH, 8'h41, CH_NL, CH_HIGH, 8'h62, CH_NUL,
    CH_DQUOTE, 8'h78, CH_NUL, CH_SLASH, CH_NUL, CH_NUL,
    CH_SLASH, CH_SLASH, CH_NUL
  };

  always #5 clk = ~clk;

  script_text_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_char  (token_char),
    .item_kind   (item_kind),
    .token_class (token_class),
    .last_of_run (last_of_run)
  );

  tokenizer_result_check u_result_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_char  (token_char),
    .item_kind   (item_kind),
    .token_class (token_class),
    .last_of_run (last_of_run),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] word_byte(bit first);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(33, 127));
    end while ((b inside {CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SQUOTE, CH_COMMA}) ||
               (first && (b == CH_SLASH || b == CH_DQUOTE)));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(1, 32));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] punct_byte();
    case ($urandom_range(0, 5))
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_LPAREN;
      3:       return CH_RPAREN;
      4:       return CH_SQUOTE;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] nonzero_except(logic [7:0] excluded);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == excluded);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_token();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      n = $urandom_range(1, 6);
      send_byte(word_byte(1'b1));
      repeat (n - 1) send_byte(word_byte(1'b0));
      send_byte(($urandom_range(0, 1) == 0) ? blank_byte() : punct_byte());
    end else if (r < 45) begin
      send_byte(CH_DQUOTE);
      repeat ($urandom_range(0, 6)) send_byte(nonzero_except(CH_DQUOTE));
      send_byte(CH_DQUOTE);
    end else if (r < 60) begin
      send_byte(punct_byte());
    end else if (r < 70) begin
      send_byte(CH_SLASH);
      send_byte(CH_SLASH);
      repeat ($urandom_range(0, 5)) send_byte(nonzero_except(CH_NL));
      send_byte(CH_NL);
    end else if (r < 78) begin
      repeat ($urandom_range(1, 3)) send_byte(blank_byte());
    end else if (r < 84) begin
      send_byte(CH_SLASH);
      send_byte(nonzero_except(CH_SLASH));
    end else if (r < 90) begin
      send_byte(CH_NUL);
    end else if (r < 95) begin
      send_byte(CH_DQUOTE);
      repeat ($urandom_range(0, 3)) send_byte(nonzero_except(CH_DQUOTE));
      send_byte(CH_NUL);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int free_len;
    int hold_len;
    int r;
    forever begin
      out_stall <= 1'b0;
      free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      repeat (free_len) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 60) hold_len = $urandom_range(1, 3);
      else if (r < 90) hold_len = 0;
      else hold_len = $urandom_range(10, 40);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int base;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_text[i]) send_byte(directed_text[i]);
    base = sent;
    while (sent - base < TEXT_ITEMS) begin
      if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
      send_token();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
